// ===== src/bcgd_pkg.sv =====
// Shared types and constants for the button click gesture detector.
// Used by every module of the block; depends on nothing else.
package bcgd_pkg;

  localparam int TimeW    = 32;
  localparam int CfgTimeW = 16;
  localparam int InDataW  = 40;
  localparam int OutDataW = 8;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  localparam logic [CfgTimeW-1:0] DebounceReset    = 16'd20;
  localparam logic [CfgTimeW-1:0] LongPressReset   = 16'd500;
  localparam logic [CfgTimeW-1:0] DoubleClickReset = 16'd300;
  localparam logic                ActiveLevelReset = 1'b0;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_DOUBLE   = 2'd2,
    REG_ACTIVE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_CLICK  = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DOWN  = 3'd1,
    PH_WAIT2 = 3'd2,
    PH_DOWN2 = 3'd3,
    PH_LONG  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CfgTimeW-1:0] debounce_time;
    logic [CfgTimeW-1:0] long_press_time;
    logic [CfgTimeW-1:0] double_click_window;
    logic                active_level;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic rise;
    logic fall;
  } btn_status_t;

endpackage

// ===== src/bcgd_cfg_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on bcgd_pkg.
module bcgd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcgd_pkg::CfgAddrW-1:0] paddr,
  input  logic [bcgd_pkg::CfgDataW-1:0] pwdata,
  output logic [bcgd_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output bcgd_pkg::cfg_t                cfg
);
  import bcgd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_reg_t sel;
  logic     wr_en;

  assign sel    = cfg_reg_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (sel)
        REG_DEBOUNCE: cfg_nxt.debounce_time       = pwdata[CfgTimeW-1:0];
        REG_LONG:     cfg_nxt.long_press_time     = pwdata[CfgTimeW-1:0];
        REG_DOUBLE:   cfg_nxt.double_click_window = pwdata[CfgTimeW-1:0];
        REG_ACTIVE:   cfg_nxt.active_level        = pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DEBOUNCE: prdata = {{(CfgDataW-CfgTimeW){1'b0}}, cfg_r.debounce_time};
      REG_LONG:     prdata = {{(CfgDataW-CfgTimeW){1'b0}}, cfg_r.long_press_time};
      REG_DOUBLE:   prdata = {{(CfgDataW-CfgTimeW){1'b0}}, cfg_r.double_click_window};
      REG_ACTIVE:   prdata = {{(CfgDataW-1){1'b0}}, cfg_r.active_level};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time       <= DebounceReset;
      cfg_r.long_press_time     <= LongPressReset;
      cfg_r.double_click_window <= DoubleClickReset;
      cfg_r.active_level        <= ActiveLevelReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/bcgd_debounce.sv =====
// Debouncer and edge detector: tracks the raw level, accepts it once stable,
// and reports pressed, press edge and release edge. Depends on bcgd_pkg.
module bcgd_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [bcgd_pkg::TimeW-1:0] now_ms,
  input  logic                       pin_level,
  input  bcgd_pkg::cfg_t             cfg,
  output bcgd_pkg::btn_status_t      status
);
  import bcgd_pkg::*;

  logic             last_raw_r;
  logic             stable_r;
  logic             stable_nxt;
  logic [TimeW-1:0] change_time_r;
  logic [TimeW-1:0] change_time_nxt;
  logic [TimeW-1:0] elapsed;
  logic             was_held_r;

  // After this poll the last raw level is always the sampled level; the change
  // time moves to now only when the level differs from the previous poll.
  always_comb begin
    change_time_nxt = (pin_level != last_raw_r) ? now_ms : change_time_r;
    elapsed         = now_ms - change_time_nxt;
    stable_nxt      = (elapsed >= {{(TimeW-CfgTimeW){1'b0}}, cfg.debounce_time}) ?
                      pin_level : stable_r;
    status.pressed  = (stable_nxt == cfg.active_level);
    status.rise     = status.pressed && !was_held_r;
    status.fall     = !status.pressed && was_held_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b1;
      stable_r      <= 1'b1;
      change_time_r <= '0;
      was_held_r    <= 1'b0;
    end else if (step) begin
      last_raw_r    <= pin_level;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
      was_held_r    <= status.pressed;
    end
  end

endmodule

// ===== src/bcgd_gesture_fsm.sv =====
// Five-phase gesture machine: turns press and release edges plus elapsed times
// into click, double click and long press events. Depends on bcgd_pkg.
module bcgd_gesture_fsm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [bcgd_pkg::TimeW-1:0] now_ms,
  input  bcgd_pkg::btn_status_t      status,
  input  bcgd_pkg::cfg_t             cfg,
  output bcgd_pkg::gesture_t         gesture
);
  import bcgd_pkg::*;

  phase_t           phase_r;
  phase_t           phase_nxt;
  logic [TimeW-1:0] press_time_r;
  logic [TimeW-1:0] press_time_nxt;
  logic [TimeW-1:0] release_time_r;
  logic [TimeW-1:0] release_time_nxt;
  logic [TimeW-1:0] press_elapsed;
  logic [TimeW-1:0] release_elapsed;
  logic             long_hit;
  logic             window_over;

  assign press_elapsed   = now_ms - press_time_r;
  assign release_elapsed = now_ms - release_time_r;
  assign long_hit    = status.pressed &&
                       (press_elapsed >= {{(TimeW-CfgTimeW){1'b0}}, cfg.long_press_time});
  assign window_over = release_elapsed >=
                       {{(TimeW-CfgTimeW){1'b0}}, cfg.double_click_window};

  always_comb begin
    phase_nxt        = phase_r;
    press_time_nxt   = press_time_r;
    release_time_nxt = release_time_r;
    gesture          = GEST_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (status.rise) begin
          press_time_nxt = now_ms;
          phase_nxt      = PH_DOWN;
        end
      end
      PH_DOWN: begin
        // A long press wins over a release seen in the same poll.
        if (long_hit) begin
          gesture   = GEST_LONG;
          phase_nxt = PH_LONG;
        end else if (status.fall) begin
          release_time_nxt = now_ms;
          phase_nxt        = PH_WAIT2;
        end
      end
      PH_WAIT2: begin
        if (status.rise) begin
          press_time_nxt = now_ms;
          phase_nxt      = PH_DOWN2;
        end else if (window_over) begin
          gesture   = GEST_CLICK;
          phase_nxt = PH_IDLE;
        end
      end
      PH_DOWN2: begin
        if (long_hit) begin
          gesture   = GEST_LONG;
          phase_nxt = PH_LONG;
        end else if (status.fall) begin
          gesture   = GEST_DOUBLE;
          phase_nxt = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (status.fall) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      press_time_r   <= '0;
      release_time_r <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      press_time_r   <= press_time_nxt;
      release_time_r <= release_time_nxt;
    end
  end

endmodule

// ===== src/button_click_gesture_detector.sv =====
// Button click gesture detector. Every input beat is one poll of the button
// (millisecond timestamp and raw pin level) and yields exactly one output beat
// carrying the gesture code and the debounced held flag. A beat is captured in
// an input register and then runs through the debouncer and the gesture
// machine into the output register, which updates all state at once; the
// block therefore takes one beat per cycle while the output side keeps taking.
// The user must write registers over the APB-style port only while no poll
// is pending; the block itself does not enforce this.
// Depends on bcgd_pkg, bcgd_cfg_regs, bcgd_debounce and bcgd_gesture_fsm.
module button_click_gesture_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] now_ms, [32] pin_level, [39:33] zero
  input  logic [bcgd_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] gesture, [2] held, [7:3] zero
  output logic [bcgd_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bcgd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [bcgd_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [bcgd_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import bcgd_pkg::*;

  cfg_t        cfg;
  btn_status_t status;
  gesture_t    gesture;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [TimeW-1:0] s1_now_r;
  logic             s1_pin_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  gesture_t         out_gesture_r;
  logic             out_held_r;
  logic             in_acc;
  logic             advance;

  bcgd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // The held beat moves on whenever the output register is empty or drained.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  bcgd_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .now_ms    (s1_now_r),
    .pin_level (s1_pin_r),
    .cfg       (cfg),
    .status    (status)
  );

  bcgd_gesture_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .now_ms  (s1_now_r),
    .status  (status),
    .cfg     (cfg),
    .gesture (gesture)
  );

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r <= in_tdata[TimeW-1:0];
      s1_pin_r <= in_tdata[TimeW];
    end
    if (advance) begin
      out_gesture_r <= gesture;
      out_held_r    <= status.pressed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-3){1'b0}}, out_held_r, out_gesture_r};

endmodule

// ===== src/bcgd_checker.sv =====
// Port-level checks for the button click gesture detector, bound to the top.
// Depends on bcgd_pkg and button_click_gesture_detector.
module bcgd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bcgd_pkg::OutDataW-1:0] out_tdata
);
  import bcgd_pkg::*;

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // With nothing waiting at the output, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  // A long press is reported while held; clicks are reported once released.
  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == GEST_LONG) |-> out_tdata[2])
    else $error("long press reported while released");

  a_click_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tdata[1:0] == GEST_CLICK) || (out_tdata[1:0] == GEST_DOUBLE))
      |-> !out_tdata[2])
    else $error("click reported while held");

endmodule

bind button_click_gesture_detector bcgd_checker u_bcgd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/bcgd_checker.sv =====
// Scoreboard for the button click gesture detector: snoops the poll, result and
// register ports, predicts every result beat and compares it field by field.
// Depends on bcgd_pkg.
`timescale 1ns / 1ps

module bcgd_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // [31:0] now_ms, [32] pin_level, [39:33] zero
  input  logic [bcgd_pkg::InDataW-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] gesture, [2] held, [7:3] zero
  input  logic [bcgd_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [bcgd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [bcgd_pkg::CfgDataW-1:0] cfg_pwdata,
  output int                            results_pending,
  output int                            mismatches
);
  import bcgd_pkg::*;

  typedef struct packed {
    gesture_t gesture;
    logic     held;
  } poll_result_t;

  poll_result_t expected_gestures[$];
  poll_result_t want;
  gesture_t     got_gesture;
  int           fail_count;

  // Predicted button state and register copy.
  cfg_t        cfg;
  logic        last_raw;
  logic        stable_lvl;
  logic [31:0] change_ms;
  logic [31:0] press_ms;
  logic [31:0] release_ms;
  logic        was_down;
  phase_t      phase;

  task automatic classify_poll(input logic [31:0] now, input logic raw);
    logic     down;
    logic     rise;
    logic     fall;
    gesture_t gest;
    gest = GEST_NONE;
    if (raw != last_raw) begin
      last_raw  = raw;
      change_ms = now;
    end
    if (now - change_ms >= 32'(cfg.debounce_time)) stable_lvl = last_raw;
    down     = (stable_lvl == cfg.active_level);
    rise     = down & ~was_down;
    fall     = ~down & was_down;
    was_down = down;
    case (phase)
      PH_IDLE: begin
        if (rise) begin
          press_ms = now;
          phase    = PH_DOWN;
        end
      end
      PH_DOWN: begin
        // A press held long enough wins over anything else in this poll.
        if (down && (now - press_ms >= 32'(cfg.long_press_time))) begin
          gest  = GEST_LONG;
          phase = PH_LONG;
        end else if (fall) begin
          release_ms = now;
          phase      = PH_WAIT2;
        end
      end
      PH_WAIT2: begin
        if (rise) begin
          press_ms = now;
          phase    = PH_DOWN2;
        end else if (now - release_ms >= 32'(cfg.double_click_window)) begin
          gest  = GEST_CLICK;
          phase = PH_IDLE;
        end
      end
      PH_DOWN2: begin
        if (down && (now - press_ms >= 32'(cfg.long_press_time))) begin
          gest  = GEST_LONG;
          phase = PH_LONG;
        end else if (fall) begin
          gest  = GEST_DOUBLE;
          phase = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (fall) phase = PH_IDLE;
      end
      default: phase = PH_IDLE;
    endcase
    expected_gestures.push_back('{gesture: gest, held: down});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg.debounce_time       = DebounceReset;
      cfg.long_press_time     = LongPressReset;
      cfg.double_click_window = DoubleClickReset;
      cfg.active_level        = ActiveLevelReset;
      last_raw   = ~ActiveLevelReset;
      stable_lvl = ~ActiveLevelReset;
      change_ms  = '0;
      press_ms   = '0;
      release_ms = '0;
      was_down   = 1'b0;
      phase      = PH_IDLE;
      fail_count = 0;
      expected_gestures.delete();
    end else begin
      // A result beat can never stem from a poll accepted at the same edge.
      if (out_tvalid && out_tready) begin
        got_gesture = gesture_t'(out_tdata[1:0]);
        if (expected_gestures.size() == 0) begin
          $error("unexpected result beat: gesture %s held %0b",
                 got_gesture.name(), out_tdata[2]);
          fail_count++;
        end else begin
          want = expected_gestures.pop_front();
          if (got_gesture != want.gesture) begin
            $error("gesture: expected %s, actual %s", want.gesture.name(),
                   got_gesture.name());
            fail_count++;
          end
          if (out_tdata[2] != want.held) begin
            $error("held: expected %0b, actual %0b", want.held, out_tdata[2]);
            fail_count++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_reg_t'(cfg_paddr[3:2]))
          REG_DEBOUNCE: cfg.debounce_time       = cfg_pwdata[15:0];
          REG_LONG:     cfg.long_press_time     = cfg_pwdata[15:0];
          REG_DOUBLE:   cfg.double_click_window = cfg_pwdata[15:0];
          REG_ACTIVE:   cfg.active_level        = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) classify_poll(in_tdata[31:0], in_tdata[32]);
    end
    results_pending <= expected_gestures.size();
    mismatches      <= fail_count;
  end

endmodule

// ===== tb/tb_button_click_gesture_detector.sv =====
// Top of the gesture detector testbench: clock, reset, register writes and
// button poll stimulus; checking is done by bcgd_scoreboard.
// Depends on bcgd_pkg, bcgd_scoreboard and button_click_gesture_detector.
`timescale 1ns / 1ps

module tb_button_click_gesture_detector;
  import bcgd_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;
  int                  results_pending;
  int                  mismatches;

  // Current register settings, used to shape the button gestures.
  int unsigned deb_ms;
  int unsigned long_ms;
  int unsigned win_ms;
  logic        act_lvl;
  logic [31:0] now_t;
  int unsigned burst_left;
  int unsigned polls_sent;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  always #6 clk = ~clk;

  button_click_gesture_detector dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  bcgd_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .results_pending(results_pending), .mismatches(mismatches)
  );

  // The result side switches between always ready, coin flips and long stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Every task below starts and ends right after a rising edge.
  task automatic send_poll(input logic [31:0] t, input logic pin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW-33){1'b0}}, pin, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    polls_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_settings(input int unsigned deb, input int unsigned lng,
                                input int unsigned win, input logic act);
    drain_results();
    repeat (4) @(posedge clk);
    // Upper bits are junk on purpose; the registers keep only their own width.
    write_reg(REG_DEBOUNCE, {16'($urandom_range(0, 65535)), deb[15:0]});
    write_reg(REG_LONG, {16'($urandom_range(0, 65535)), lng[15:0]});
    write_reg(REG_DOUBLE, {16'($urandom_range(0, 65535)), win[15:0]});
    write_reg(REG_ACTIVE, {31'($urandom), act});
    deb_ms  = deb;
    long_ms = lng;
    win_ms  = win;
    act_lvl = act;
  endtask

  // Polls one pin level at random steps until the given time has passed.
  task automatic hold_pin(input logic lvl, input int unsigned dur);
    int unsigned done;
    int unsigned step;
    done = 0;
    do begin
      send_poll(now_t, lvl);
      step  = $urandom_range(1, dur / 3 + 1);
      now_t += step;
      done  += step;
    end while (done < dur);
  endtask

  task automatic do_click();
    hold_pin(act_lvl, deb_ms + $urandom_range(1, long_ms / 2 + 1));
    hold_pin(~act_lvl, deb_ms + win_ms + $urandom_range(1, win_ms / 2 + 2));
  endtask

  task automatic run_gesture();
    int unsigned kind;
    logic [31:0] t0;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: do_click();
      3, 4: begin
        hold_pin(act_lvl, deb_ms + $urandom_range(1, long_ms / 2 + 1));
        hold_pin(~act_lvl, deb_ms + $urandom_range(1, win_ms / 2 + 1));
        hold_pin(act_lvl, deb_ms + $urandom_range(1, long_ms / 2 + 1));
        hold_pin(~act_lvl, deb_ms + win_ms + $urandom_range(1, win_ms / 2 + 2));
      end
      5: begin
        hold_pin(act_lvl, deb_ms + long_ms + $urandom_range(1, long_ms / 2 + 2));
        hold_pin(~act_lvl, deb_ms + $urandom_range(1, win_ms + 2));
      end
      6: begin
        // Contact bounce shorter than the debounce time.
        repeat ($urandom_range(2, 6)) hold_pin(1'($urandom_range(0, 1)),
                                               $urandom_range(0, deb_ms / 2 + 1));
      end
      7: begin
        // Polls one ms short of and exactly at each threshold but the release debounce.
        t0 = now_t;
        send_poll(t0, act_lvl);
        send_poll(t0 + deb_ms - 1, act_lvl);
        send_poll(t0 + deb_ms, act_lvl);
        send_poll(t0 + deb_ms + long_ms - 1, act_lvl);
        send_poll(t0 + deb_ms + long_ms, act_lvl);
        t0 = t0 + deb_ms + long_ms + 1;
        send_poll(t0, ~act_lvl);
        send_poll(t0 + deb_ms, ~act_lvl);
        send_poll(t0 + deb_ms + win_ms - 1, ~act_lvl);
        send_poll(t0 + deb_ms + win_ms, ~act_lvl);
        now_t = t0 + deb_ms + win_ms + 1;
      end
      8: begin
        repeat ($urandom_range(1, 8)) begin
          now_t = $urandom;
          send_poll(now_t, 1'($urandom_range(0, 1)));
        end
      end
      default: begin
        // Gesture that starts near the wrap of the millisecond counter and may straddle it.
        now_t = 32'hFFFF_FFFF - $urandom_range(0, deb_ms + long_ms + win_ms);
        do_click();
      end
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = polls_sent + count;
    while (polls_sent < target) begin
      run_gesture();
      if ($urandom_range(0, 29) == 0) drain_results();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    out_tready  <= 1'b0;
    deb_ms      = 32'(DebounceReset);
    long_ms     = 32'(LongPressReset);
    win_ms      = 32'(DoubleClickReset);
    act_lvl     = ActiveLevelReset;
    now_t       = '0;
    burst_left  = 0;
    polls_sent  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, active low: click, double click, long press, then wrap
    // of the timestamp and a timestamp going backwards.
    send_poll(32'd0, 1'b1);
    send_poll(32'd5, 1'b0);
    send_poll(32'd24, 1'b0);
    send_poll(32'd25, 1'b0);
    send_poll(32'd100, 1'b1);
    send_poll(32'd120, 1'b1);
    send_poll(32'd419, 1'b1);
    send_poll(32'd420, 1'b1);
    send_poll(32'd440, 1'b0);
    send_poll(32'd460, 1'b0);
    send_poll(32'd470, 1'b1);
    send_poll(32'd490, 1'b1);
    send_poll(32'd500, 1'b0);
    send_poll(32'd520, 1'b0);
    send_poll(32'd530, 1'b1);
    send_poll(32'd550, 1'b1);
    send_poll(32'd600, 1'b0);
    send_poll(32'd620, 1'b0);
    send_poll(32'd1119, 1'b0);
    send_poll(32'd1120, 1'b0);
    send_poll(32'd1130, 1'b1);
    send_poll(32'd1150, 1'b1);
    send_poll(32'hFFFF_FFF0, 1'b0);
    send_poll(32'h0000_0004, 1'b0);
    send_poll(32'h0000_0002, 1'b1);
    now_t = 32'd2000;
    drain_results();

    run_random(230);
    apply_settings(5, 40, 30, 1'b1);
    run_random(260);
    apply_settings(0, 0, 0, 1'b0);
    run_random(200);
    apply_settings(65535, 65535, 65535, 1'b1);
    run_random(230);
    apply_settings(0, 65535, 1, 1'b1);
    run_random(230);
    apply_settings(3, 25, 12, 1'b0);
    run_random(250);
    apply_settings($urandom_range(0, 30), $urandom_range(0, 200),
                   $urandom_range(0, 120), 1'($urandom_range(0, 1)));
    run_random(250);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bcgd_pkg.sv
src/bcgd_cfg_regs.sv
src/bcgd_debounce.sv
src/bcgd_gesture_fsm.sv
src/button_click_gesture_detector.sv
src/bcgd_checker.sv
tb/bcgd_checker.sv
tb/tb_button_click_gesture_detector.sv
